FILE: sv/h2r_pkg.sv
// Shared constants, types and helper functions for the HSL to RGB pixel pipeline.
package h2r_pkg;

   localparam int unsigned FRAC_W = 16;             // Q0.16 input fractions
   localparam int unsigned UNIT_W = FRAC_W + 1;     // values up to and including one unit
   localparam int unsigned LVL_W  = UNIT_W + 1;     // ramp level with small overshoot
   localparam int unsigned CH_N   = 3;              // red, green, blue

   localparam int unsigned CH_RED   = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 2;

   localparam logic [FRAC_W-1:0] GREY_LIM   = 16'd66;
   localparam logic [FRAC_W-1:0] HALF       = 16'd32768;
   localparam logic [FRAC_W-1:0] THIRD      = 16'd21845;
   localparam logic [FRAC_W-1:0] NEG_THIRD  = 16'd43691;   // one turn minus one third
   localparam logic [FRAC_W-1:0] SIXTH      = 16'd10923;
   localparam logic [FRAC_W-1:0] TWO_THIRDS = 16'd43691;

   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [UNIT_W-1:0] unit_type;
   typedef logic [UNIT_W-1:0] gain_type;
   typedef logic [LVL_W-1:0]  level_type;

   // Which piece of the hue ramp a hue point falls on.
   typedef enum logic [1:0] {
      SEG_RAMP = 2'b00,
      SEG_Q    = 2'b01,
      SEG_P    = 2'b10
   } seg_type;

   typedef struct packed {
      seg_type  seg;
      gain_type gain;
   } hue_pt_type;

   // Everything the ramp stages need for one pixel.
   typedef struct packed {
      unit_type                     p;
      unit_type                     q;
      unit_type                     d;
      seg_type  [CH_N-1:0]          seg;
      gain_type [CH_N-1:0]          gain;
   } chroma_type;

   typedef struct packed {
      level_type [CH_N-1:0] lvl;
   } level_set_type;

   // Classifies a hue point and forms the ramp slope factor 6*t or 6*(2/3 - t).
   function automatic hue_pt_type hue_point(input frac_type t);
      hue_pt_type       r;
      logic [FRAC_W+2:0] six;
      frac_type          remain;
      r      = '{seg: SEG_P, gain: '0};
      six    = '0;
      remain = '0;
      if (t < SIXTH) begin
         six    = (FRAC_W+3)'(t) * (FRAC_W+3)'(6);
         r.seg  = SEG_RAMP;
         r.gain = six[UNIT_W-1:0];
      end else if (t < HALF) begin
         r.seg = SEG_Q;
      end else if (t < TWO_THIRDS) begin
         remain = TWO_THIRDS - t;
         six    = (FRAC_W+3)'(remain) * (FRAC_W+3)'(6);
         r.seg  = SEG_RAMP;
         r.gain = six[UNIT_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/hsl_to_rgb_pixel.sv
// Top level of the HSL to RGB pixel converter.
//
// The converter takes one pixel per item as hue, saturation and lightness, each an
// unsigned Q0.16 fraction, and returns one item of 8-bit red, green and blue. It is a
// five-stage pipeline that accepts a new pixel in every clock cycle as long as the
// result side keeps taking items. Every stage carries its own valid bit and is loaded
// whenever it is empty or its successor moves, so a stall on the result side only
// backs up as far as the pipeline is full, and bubbles are squeezed out. Nothing is
// dropped or repeated under back-pressure. A pixel whose saturation is below 66
// (about 0.001) comes out grey, with all three channels taken from lightness. Hue
// offsets of plus and minus one third wrap around the full turn, and a channel level
// that slightly exceeds one unit through constant rounding saturates at 255.
//
// Stage A registers the pixel and the 16x16 lightness-saturation product. Stage B
// forms q and p and classifies the three hue points. Stage C forms the 17x17 slope
// products, stage D adds them to the base level, and stage E scales by 255 into the
// output register.
module hsl_to_rgb_pixel
   import h2r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_hue,
   input  logic [15:0] req_saturation,
   input  logic [15:0] req_lightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   logic          chroma_valid;
   logic          chroma_ready;
   chroma_type    chroma_data;
   logic          level_valid;
   logic          level_ready;
   level_set_type level_data;

   // Stages A and B.
   h2r_chroma u_chroma (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_hue        (req_hue),
      .in_saturation (req_saturation),
      .in_lightness  (req_lightness),
      .out_valid     (chroma_valid),
      .out_ready     (chroma_ready),
      .out_data      (chroma_data)
   );

   // Stages C and D.
   h2r_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chroma_valid),
      .in_ready  (chroma_ready),
      .in_data   (chroma_data),
      .out_valid (level_valid),
      .out_ready (level_ready),
      .out_data  (level_data)
   );

   // Stage E, which is also the output register.
   h2r_byte u_byte (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (level_valid),
      .in_ready  (level_ready),
      .in_data   (level_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

FILE: sv/h2r_chroma.sv
// Front of the pipeline: lightness times saturation, then q, p and the three hue points.
module h2r_chroma
   import h2r_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  frac_type   in_hue,
   input  frac_type   in_saturation,
   input  frac_type   in_lightness,
   output logic       out_valid,
   input  logic       out_ready,
   output chroma_type out_data
);

   // Stage A: input registers and the l*s product.
   logic     a_valid_ff;
   logic     a_ready;
   frac_type a_hue_ff, a_sat_ff, a_light_ff, a_prod_ff;
   frac_type a_prod_in;
   logic [2*FRAC_W-1:0] a_mult;

   // Stage B: q, p, d and the hue segments.
   logic       b_valid_ff;
   logic       b_ready;
   chroma_type b_data_ff;
   chroma_type b_data_in;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_mult    = (2*FRAC_W)'(in_lightness) * (2*FRAC_W)'(in_saturation);
   assign a_prod_in = a_mult[2*FRAC_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_hue_ff   <= in_hue;
         a_sat_ff   <= in_saturation;
         a_light_ff <= in_lightness;
         a_prod_ff  <= a_prod_in;
      end
   end

   logic [UNIT_W:0]   b_sum;
   unit_type          b_q;
   unit_type          b_two_l;
   logic [UNIT_W:0]   b_diff;
   unit_type          b_p;
   frac_type          t_red, t_blue;
   hue_pt_type        pt_red, pt_green, pt_blue;

   always_comb begin
      // For dark pixels q = l + l*s; for light ones q = l + s - l*s.
      if (a_light_ff < HALF) begin
         b_sum = (UNIT_W+1)'(a_light_ff) + (UNIT_W+1)'(a_prod_ff);
      end else begin
         b_sum = (UNIT_W+1)'(a_light_ff) + (UNIT_W+1)'(a_sat_ff)
               - (UNIT_W+1)'(a_prod_ff);
      end
      b_q     = b_sum[UNIT_W-1:0];
      b_two_l = {a_light_ff, 1'b0};
      b_diff  = {1'b0, b_two_l} - {1'b0, b_q};
      b_p     = b_diff[UNIT_W] ? '0 : b_diff[UNIT_W-1:0];

      t_red    = a_hue_ff + THIRD;
      t_blue   = a_hue_ff + NEG_THIRD;
      pt_red   = hue_point(t_red);
      pt_green = hue_point(a_hue_ff);
      pt_blue  = hue_point(t_blue);

      b_data_in = '0;
      b_data_in.seg[CH_RED]    = pt_red.seg;
      b_data_in.seg[CH_GREEN]  = pt_green.seg;
      b_data_in.seg[CH_BLUE]   = pt_blue.seg;
      b_data_in.gain[CH_RED]   = pt_red.gain;
      b_data_in.gain[CH_GREEN] = pt_green.gain;
      b_data_in.gain[CH_BLUE]  = pt_blue.gain;

      // A grey pixel collapses the ramp: every piece then yields lightness.
      if (a_sat_ff < GREY_LIM) begin
         b_data_in.p = UNIT_W'(a_light_ff);
         b_data_in.q = UNIT_W'(a_light_ff);
         b_data_in.d = '0;
      end else begin
         b_data_in.p = b_p;
         b_data_in.q = b_q;
         b_data_in.d = (b_q >= b_p) ? (b_q - b_p) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

FILE: sv/h2r_ramp.sv
// Hue ramp evaluation for the three channels: slope product, then the level sum.
module h2r_ramp
   import h2r_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  chroma_type    in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output level_set_type out_data
);

   // Stage C: base level and the scaled slope product per channel.
   logic                 c_valid_ff;
   logic                 c_ready;
   unit_type  [CH_N-1:0] c_base_ff, c_base_in;
   level_type [CH_N-1:0] c_step_ff, c_step_in;
   logic [2*UNIT_W-1:0]  c_mult [CH_N];

   // Stage D: channel level.
   logic          d_valid_ff;
   logic          d_ready;
   level_set_type d_data_ff, d_data_in;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   always_comb begin
      for (int ch = 0; ch < CH_N; ch++) begin
         c_mult[ch]    = (2*UNIT_W)'(in_data.d) * (2*UNIT_W)'(in_data.gain[ch]);
         c_base_in[ch] = in_data.p;
         c_step_in[ch] = '0;
         unique case (in_data.seg[ch])
            SEG_RAMP: c_step_in[ch] = c_mult[ch][2*UNIT_W-1:FRAC_W];
            SEG_Q:    c_base_in[ch] = in_data.q;
            SEG_P:    c_base_in[ch] = in_data.p;
            default:  c_base_in[ch] = in_data.p;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= in_valid;
      end
      if (c_ready && in_valid) begin
         c_base_ff <= c_base_in;
         c_step_ff <= c_step_in;
      end
   end

   always_comb begin
      for (int ch = 0; ch < CH_N; ch++) begin
         d_data_in.lvl[ch] = LVL_W'(c_base_ff[ch]) + c_step_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

FILE: sv/h2r_byte.sv
// Output stage: scales each channel level by 255 into a saturated byte.
module h2r_byte
   import h2r_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  level_set_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_red,
   output logic [7:0]    out_green,
   output logic [7:0]    out_blue
);

   localparam int unsigned SCL_W = LVL_W + 8;

   logic             e_valid_ff;
   logic             e_ready;
   logic [CH_N-1:0][7:0] e_byte_ff, e_byte_in;
   logic [SCL_W-1:0] e_scaled [CH_N];
   logic [SCL_W-FRAC_W-1:0] e_whole [CH_N];

   assign e_ready  = !e_valid_ff || out_ready;
   assign in_ready = e_ready;

   always_comb begin
      for (int ch = 0; ch < CH_N; ch++) begin
         // Times 255 as a shift and subtract.
         e_scaled[ch] = {in_data.lvl[ch], 8'd0} - SCL_W'(in_data.lvl[ch]);
         e_whole[ch]  = e_scaled[ch][SCL_W-1:FRAC_W];
         e_byte_in[ch] = (e_whole[ch] > (SCL_W-FRAC_W)'(255)) ? 8'hFF : e_whole[ch][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_ready) begin
         e_valid_ff <= in_valid;
      end
      if (e_ready && in_valid) begin
         e_byte_ff <= e_byte_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_red   = e_byte_ff[CH_RED];
   assign out_green = e_byte_ff[CH_GREEN];
   assign out_blue  = e_byte_ff[CH_BLUE];

endmodule
